[hdl/d8_flow_direction_unit_macros.svh]
// assertion helpers for the checker file
`ifndef D8_FLOW_DIRECTION_UNIT_MACROS_SVH
`define D8_FLOW_DIRECTION_UNIT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define D8FD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("d8fd check failed");

// next-cycle implication, off while reset is asserted
`define D8FD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("d8fd check failed");

`endif

[hdl/d8fd_pkg.sv]
package d8fd_pkg;

    // heights and derived widths
    localparam int HEIGHT_BITS = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int DROP_W      = HEIGHT_BITS + 1;
    localparam int WEIGHT_W    = 16;
    localparam int SCORE_W     = DROP_W + WEIGHT_W;
    localparam int NUM_DIR     = 8;
    localparam int DIR_W       = 3;
    localparam int CODE_W      = 4;

    // 1/sqrt2 in Q0.16; orthogonal weight is a shift by WEIGHT_W
    localparam logic [WEIGHT_W-1:0] WEIGHT_DIAG = 16'd46341;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEA_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAT_TOL   = 2'd1;

    // flow codes beyond the eight directions
    localparam logic [CODE_W-1:0] CODE_OCEAN    = 4'd8;
    localparam logic [CODE_W-1:0] CODE_BOUNDARY = 4'd9;
    localparam logic [CODE_W-1:0] CODE_FLAT     = 4'd10;
    localparam logic [CODE_W-1:0] CODE_PIT      = 4'd11;

    typedef logic [DIR_W-1:0] dir_t;
    typedef logic signed [HEIGHT_BITS-1:0] height_t;

    // one 3x3 window, neighbours in direction-code order
    typedef struct packed {
        height_t                            center;
        logic                               boundary;
        logic [NUM_DIR-1:0][HEIGHT_BITS-1:0] nb;
    } window_t;

    // weighted drop toward one neighbour
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        dir_t                      dir;
    } cand_t;

    // per-cell class flags
    typedef struct packed {
        logic ocean;
        logic boundary;
        logic flat_ok;
    } cls_t;

endpackage

[hdl/d8fd_cell_if.sv]
interface d8fd_cell_if;
    import d8fd_pkg::*;

    logic    valid;
    logic    ready;
    height_t center_height;
    logic    at_boundary;
    height_t east_height;
    height_t southeast_height;
    height_t south_height;
    height_t southwest_height;
    height_t west_height;
    height_t northwest_height;
    height_t north_height;
    height_t northeast_height;

    modport source (
        output valid, center_height, at_boundary, east_height, southeast_height,
               south_height, southwest_height, west_height, northwest_height,
               north_height, northeast_height,
        input  ready
    );

    modport sink (
        input  valid, center_height, at_boundary, east_height, southeast_height,
               south_height, southwest_height, west_height, northwest_height,
               north_height, northeast_height,
        output ready
    );
endinterface

[hdl/d8fd_flow_if.sv]
interface d8fd_flow_if;
    import d8fd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] flow_code;

    modport source (
        output valid, flow_code,
        input  ready
    );

    modport sink (
        input  valid, flow_code,
        output ready
    );
endinterface

[hdl/d8fd_cfg_if.sv]
interface d8fd_cfg_if;
    import d8fd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[hdl/d8fd_weight.sv]
module d8fd_weight (
    input  d8fd_pkg::window_t                 win,
    input  logic [d8fd_pkg::CFG_DATA_W-1:0]   sea_level,
    input  logic [d8fd_pkg::CFG_DATA_W-1:0]   flat_tol,
    output d8fd_pkg::cand_t                   cand [d8fd_pkg::NUM_DIR],
    output d8fd_pkg::cls_t                    cls
);
    import d8fd_pkg::*;

    logic signed [SCORE_W-1:0] c_ext;
    logic signed [SCORE_W-1:0] sea_ext;
    logic signed [DROP_W-1:0]  tol_ext;
    logic signed [SCORE_W-1:0] diag_w;
    logic [NUM_DIR-1:0]        within_tol;

    // sign-extended centre and sea level for the ocean test
    assign c_ext   = {{(SCORE_W-HEIGHT_BITS){win.center[HEIGHT_BITS-1]}}, win.center};
    assign sea_ext = {{(SCORE_W-CFG_DATA_W){sea_level[CFG_DATA_W-1]}}, sea_level};
    assign tol_ext = {{(DROP_W-CFG_DATA_W){1'b0}}, flat_tol};
    assign diag_w  = {{(SCORE_W-WEIGHT_W){1'b0}}, WEIGHT_DIAG};

    // weighted drop and flat test per neighbour
    always_comb
    begin
        for (int i = 0; i < NUM_DIR; i++)
        begin
            logic signed [DROP_W-1:0]  c_d;
            logic signed [DROP_W-1:0]  n_d;
            logic signed [DROP_W-1:0]  drop;
            logic signed [DROP_W-1:0]  rise;
            logic signed [SCORE_W-1:0] drop_ext;
            logic signed [SCORE_W-1:0] prod;
            c_d      = {win.center[HEIGHT_BITS-1], win.center};
            n_d      = {win.nb[i][HEIGHT_BITS-1], win.nb[i]};
            drop     = c_d - n_d;
            rise     = n_d - c_d;
            drop_ext = {{(SCORE_W-DROP_W){drop[DROP_W-1]}}, drop};
            prod     = drop_ext * diag_w;
            cand[i].dir = DIR_W'(i);
            // odd codes are diagonal
            if (i % 2 == 1)
            begin
                cand[i].score = prod;
            end
            else
            begin
                cand[i].score = {drop, {WEIGHT_W{1'b0}}};
            end
            within_tol[i] = (rise <= tol_ext);
        end
    end

    assign cls.ocean    = (c_ext < sea_ext);
    assign cls.boundary = win.boundary;
    assign cls.flat_ok  = &within_tol;

endmodule

[hdl/d8_flow_direction_unit.sv]
// d8 flow direction classifier
// window channel: one 3x3 heightmap window per request (centre, edge flag and
// the eight neighbour heights, east first, clockwise through northeast)
// flow channel: one 4-bit flow code per window, in request order
//   0-7 steepest downhill direction, 8 ocean, 9 boundary, 10 flat, 11 pit
// cfg channel: register 0 sea level, register 1 flat tolerance; always ready,
//   write only while no window is in flight
// path: an accepted window passes the input register, weighting, two compare levels
//   and the result register before its code is on the flow channel
// throughput: one window per cycle while flow is not stalled, set by the five-stage pipeline
// stall: each stage holds while the next is full and stalled; empty stages
//   still fill, so up to five windows can sit in the block when flow stalls
// reset: clears all stage valids and both registers to zero
module d8_flow_direction_unit (
    input  logic        clk,
    input  logic        rst_n,
    d8fd_cell_if.sink   window,
    d8fd_flow_if.source flow,
    d8fd_cfg_if.sink    cfg
);
    import d8fd_pkg::*;

    logic [CFG_DATA_W-1:0] sea_level_reg;
    logic [CFG_DATA_W-1:0] flat_tol_reg;

    logic    win_vld_reg, wgt_vld_reg, red4_vld_reg, red2_vld_reg, out_vld_reg;
    logic    win_rdy, wgt_rdy, red4_rdy, red2_rdy, out_rdy;

    window_t win_reg;
    window_t win_next;
    cand_t   wgt_cand [NUM_DIR];
    cls_t    wgt_cls;
    cand_t   wgt_reg  [NUM_DIR];
    cls_t    wgt_cls_reg;
    cand_t   red4_next [NUM_DIR/2];
    cand_t   red4_reg  [NUM_DIR/2];
    cls_t    red4_cls_reg;
    cand_t   red2_next [NUM_DIR/4];
    cand_t   red2_reg  [NUM_DIR/4];
    cls_t    red2_cls_reg;
    cand_t   best;
    logic [CODE_W-1:0] code_next;
    logic [CODE_W-1:0] code_reg;

    // lower direction keeps a tie
    function automatic cand_t best_of(cand_t a, cand_t b);
        cand_t r;
        r = a;
        if ($signed(b.score) > $signed(a.score))
        begin
            r = b;
        end
        return r;
    endfunction

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sea_level_reg <= '0;
            flat_tol_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SEA_LEVEL: sea_level_reg <= cfg.data;
                REG_FLAT_TOL:  flat_tol_reg  <= cfg.data;
                default:       ;
            endcase
        end
    end

    // stage handshake: a stage loads when it is empty or its item moves on
    assign out_rdy      = !out_vld_reg  || flow.ready;
    assign red2_rdy     = !red2_vld_reg || out_rdy;
    assign red4_rdy     = !red4_vld_reg || red2_rdy;
    assign wgt_rdy      = !wgt_vld_reg  || red4_rdy;
    assign win_rdy      = !win_vld_reg  || wgt_rdy;
    assign window.ready = win_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_vld_reg  <= 1'b0;
            wgt_vld_reg  <= 1'b0;
            red4_vld_reg <= 1'b0;
            red2_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (win_rdy)
            begin
                win_vld_reg <= window.valid;
            end
            if (wgt_rdy)
            begin
                wgt_vld_reg <= win_vld_reg;
            end
            if (red4_rdy)
            begin
                red4_vld_reg <= wgt_vld_reg;
            end
            if (red2_rdy)
            begin
                red2_vld_reg <= red4_vld_reg;
            end
            if (out_rdy)
            begin
                out_vld_reg <= red2_vld_reg;
            end
        end
    end

    // input register
    assign win_next.center   = window.center_height;
    assign win_next.boundary = window.at_boundary;
    assign win_next.nb[0]    = window.east_height;
    assign win_next.nb[1]    = window.southeast_height;
    assign win_next.nb[2]    = window.south_height;
    assign win_next.nb[3]    = window.southwest_height;
    assign win_next.nb[4]    = window.west_height;
    assign win_next.nb[5]    = window.northwest_height;
    assign win_next.nb[6]    = window.north_height;
    assign win_next.nb[7]    = window.northeast_height;

    always_ff @(posedge clk)
    begin
        if (win_rdy && window.valid)
        begin
            win_reg <= win_next;
        end
    end

    // weighted drops and class flags
    d8fd_weight u_weight (
        .win       (win_reg),
        .sea_level (sea_level_reg),
        .flat_tol  (flat_tol_reg),
        .cand      (wgt_cand),
        .cls       (wgt_cls)
    );

    always_ff @(posedge clk)
    begin
        if (wgt_rdy && win_vld_reg)
        begin
            wgt_reg     <= wgt_cand;
            wgt_cls_reg <= wgt_cls;
        end
    end

    // first compare level: eight to four
    always_comb
    begin
        for (int i = 0; i < NUM_DIR/2; i++)
        begin
            red4_next[i] = best_of(wgt_reg[2*i], wgt_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (red4_rdy && wgt_vld_reg)
        begin
            red4_reg     <= red4_next;
            red4_cls_reg <= wgt_cls_reg;
        end
    end

    // second compare level: four to two
    always_comb
    begin
        for (int i = 0; i < NUM_DIR/4; i++)
        begin
            red2_next[i] = best_of(red4_reg[2*i], red4_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (red2_rdy && red4_vld_reg)
        begin
            red2_reg     <= red2_next;
            red2_cls_reg <= red4_cls_reg;
        end
    end

    // last compare and class selection
    assign best = best_of(red2_reg[0], red2_reg[1]);

    always_comb
    begin
        priority if (red2_cls_reg.ocean)
        begin
            code_next = CODE_OCEAN;
        end
        else if (red2_cls_reg.boundary)
        begin
            code_next = CODE_BOUNDARY;
        end
        else if ($signed(best.score) > $signed({SCORE_W{1'b0}}))
        begin
            code_next = {{(CODE_W-DIR_W){1'b0}}, best.dir};
        end
        else if (red2_cls_reg.flat_ok)
        begin
            code_next = CODE_FLAT;
        end
        else
        begin
            code_next = CODE_PIT;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_rdy && red2_vld_reg)
        begin
            code_reg <= code_next;
        end
    end

    assign flow.valid     = out_vld_reg;
    assign flow.flow_code = code_reg;

endmodule

[hdl/d8fd_checker.sv]
`include "d8_flow_direction_unit_macros.svh"

module d8fd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cell_ready,
    input logic                        flow_valid,
    input logic                        flow_ready,
    input logic [d8fd_pkg::CODE_W-1:0] flow_code,
    input logic                        cfg_ready
);
    import d8fd_pkg::*;

    // a stalled result stays put
    `D8FD_ASSERT_NEXT(a_flow_hold, clk, rst_n, flow_valid && !flow_ready, flow_valid && $stable(flow_code))

    // only defined codes leave the block
    `D8FD_ASSERT_NOW(a_code_range, clk, rst_n, flow_valid, flow_code <= CODE_PIT)

    // an empty result register never blocks the input
    `D8FD_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !flow_valid, cell_ready)

    // configuration is never refused
    `D8FD_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind d8_flow_direction_unit d8fd_checker u_d8fd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_ready (window.ready),
    .flow_valid (flow.valid),
    .flow_ready (flow.ready),
    .flow_code  (flow.flow_code),
    .cfg_ready  (cfg.ready)
);
